>>> src/rlc_pkg.sv
package rlc_pkg;

  localparam int RUN_W       = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } rlc_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_step;
    logic       line_done;
  } rlc_out_t;

  typedef enum logic {
    CMD_RUN,
    CMD_REPEAT
  } cmd_kind_t;

  // One unit of work for the back end: a coded run or a repeated byte
  typedef struct packed {
    cmd_kind_t        kind;
    logic [7:0]       ch;
    logic [RUN_W-1:0] len;
    logic             last;
    logic             done;
  } rlc_cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_TENS,
    BK_ONES,
    BK_CHAR,
    BK_REP
  } back_state_t;

  // Split a run length (0..64) into decimal tens and ones by reciprocal
  function automatic logic [7:0] split_digits(input logic [RUN_W-1:0] len);
    logic [10:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones;
    prod     = 11'(len) * 11'd13;
    tens     = prod[10:7];
    tens_x10 = (7'(tens) << 3) + (7'(tens) << 1);
    ones     = len - tens_x10;
    return {tens, ones[3:0]};
  endfunction

endpackage

>>> src/rlc_front.sv
module rlc_front #(
  parameter int MAX_RUN = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data,
  input  logic             item_valid,
  output logic             item_ready,
  input  rlc_pkg::rlc_in_t item,
  output logic             push,
  output rlc_pkg::rlc_cmd_t push_cmd,
  input  logic             q_full
);
  import rlc_pkg::*;

  localparam logic [RUN_W-1:0] MAX_LEN = RUN_W'(MAX_RUN);

  logic             mode;
  logic [7:0]       held_char, held_char_next;
  logic [RUN_W-1:0] run_length, run_length_next;
  logic             have_held, have_held_next;
  logic [RUN_W-1:0] count_acc, count_acc_next;
  logic             seen_digit, seen_digit_next;
  rlc_cmd_t         pend, pend_next;
  logic             pend_valid, pend_valid_next;

  logic             accept;
  logic             cfg_write;
  logic             is_digit;
  logic [3:0]       dval;
  logic [9:0]       acc10;
  logic [RUN_W-1:0] acc_sat;
  logic             has1, has2;
  rlc_cmd_t         cmd1, cmd2;
  logic [RUN_W-1:0] reps;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign item_ready = !pend_valid && !q_full;
  assign accept     = item_valid && item_ready;

  assign is_digit = (item.in_char >= CH_ZERO) && (item.in_char <= CH_NINE);
  assign dval     = 4'(item.in_char - CH_ZERO);
  assign acc10    = (10'(count_acc) << 3) + (10'(count_acc) << 1) + 10'(dval);
  assign acc_sat  = (acc10 > 10'(MAX_RUN)) ? MAX_LEN : acc10[RUN_W-1:0];
  assign reps     = seen_digit ? count_acc : RUN_W'(1);

  always_comb begin
    held_char_next  = held_char;
    run_length_next = run_length;
    have_held_next  = have_held;
    count_acc_next  = count_acc;
    seen_digit_next = seen_digit;
    has1 = 1'b0;
    has2 = 1'b0;
    cmd1 = '{kind: CMD_RUN, ch: held_char, len: run_length, last: 1'b1, done: 1'b0};
    cmd2 = '{kind: CMD_RUN, ch: item.in_char, len: RUN_W'(1), last: 1'b1,
             done: 1'b1};
    if (accept) begin
      if (!mode) begin
        if (have_held && item.in_char == held_char && run_length < MAX_LEN) begin
          run_length_next = run_length + RUN_W'(1);
        end else begin
          has1            = have_held;
          held_char_next  = item.in_char;
          run_length_next = RUN_W'(1);
          have_held_next  = 1'b1;
        end
        if (item.line_end) begin
          // close the final run; an earlier one in the same step loses its last flag
          has2      = 1'b1;
          cmd2.ch   = held_char_next;
          cmd2.len  = run_length_next;
          cmd1.last = 1'b0;
          held_char_next  = '0;
          run_length_next = '0;
          have_held_next  = 1'b0;
        end
      end else begin
        if (is_digit) begin
          count_acc_next  = acc_sat;
          seen_digit_next = 1'b1;
          if (item.line_end) begin
            count_acc_next  = '0;
            seen_digit_next = 1'b0;
          end
        end else begin
          has1 = (reps != '0);
          cmd1 = '{kind: CMD_REPEAT, ch: item.in_char, len: reps, last: 1'b1,
                   done: item.line_end};
          count_acc_next  = '0;
          seen_digit_next = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push            = 1'b0;
    push_cmd        = pend;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    if (pend_valid) begin
      if (!q_full) begin
        push            = 1'b1;
        pend_valid_next = 1'b0;
      end
    end else if (accept) begin
      push            = has1 || has2;
      push_cmd        = has1 ? cmd1 : cmd2;
      // hold the second run until the queue takes it
      pend_valid_next = has1 && has2;
      pend_next       = cmd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      held_char  <= '0;
      run_length <= '0;
      have_held  <= 1'b0;
      count_acc  <= '0;
      seen_digit <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      held_char  <= held_char_next;
      run_length <= run_length_next;
      have_held  <= have_held_next;
      count_acc  <= count_acc_next;
      seen_digit <= seen_digit_next;
      pend_valid <= pend_valid_next;
    end
    pend <= pend_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_write) begin
      mode <= cfg_data;
    end
  end

  a_line_end_clears_run: assert property (@(posedge clk) disable iff (rst)
    accept && item.line_end && !mode && !cfg_write |=> !have_held)
    else $error("open run survived a line end");

endmodule

>>> src/rlc_queue.sv
module rlc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rlc_pkg::rlc_cmd_t push_cmd,
  input  logic              pop,
  output rlc_pkg::rlc_cmd_t head,
  output logic              full,
  output logic              empty
);
  import rlc_pkg::*;

  rlc_cmd_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop) && !(pop && empty))
    else $error("command queue overflow or underflow");

endmodule

>>> src/rlc_back.sv
module rlc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  rlc_pkg::rlc_cmd_t q_head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output rlc_pkg::rlc_out_t result
);
  import rlc_pkg::*;

  back_state_t      state, state_next;
  rlc_cmd_t         cmd, cmd_next;
  logic [RUN_W-1:0] cnt, cnt_next;
  logic [3:0]       tens, tens_next;
  logic [3:0]       ones, ones_next;
  logic             res_valid_next;
  rlc_out_t         res_next;
  logic             adv;
  logic             emit;
  rlc_out_t         emit_data;
  logic [7:0]       head_digits;

  assign adv         = !result_valid || result_ready;
  assign head_digits = split_digits(q_head.len);

  always_comb begin
    state_next = state;
    cmd_next   = cmd;
    cnt_next   = cnt;
    tens_next  = tens;
    ones_next  = ones;
    pop        = 1'b0;
    emit       = 1'b0;
    emit_data  = '{out_char: cmd.ch, last_of_step: 1'b0, line_done: 1'b0};
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop       = 1'b1;
          cmd_next  = q_head;
          cnt_next  = q_head.len;
          tens_next = head_digits[7:4];
          ones_next = head_digits[3:0];
          if (q_head.kind == CMD_REPEAT) begin
            state_next = BK_REP;
          end else if (q_head.len >= RUN_W'(10)) begin
            state_next = BK_TENS;
          end else if (q_head.len >= RUN_W'(2)) begin
            state_next = BK_ONES;
          end else begin
            state_next = BK_CHAR;
          end
        end
      end
      BK_TENS: begin
        if (adv) begin
          emit               = 1'b1;
          emit_data.out_char = CH_ZERO + 8'(tens);
          state_next         = BK_ONES;
        end
      end
      BK_ONES: begin
        if (adv) begin
          emit               = 1'b1;
          emit_data.out_char = CH_ZERO + 8'(ones);
          state_next         = BK_CHAR;
        end
      end
      BK_CHAR: begin
        if (adv) begin
          emit                   = 1'b1;
          emit_data.last_of_step = cmd.last;
          emit_data.line_done    = cmd.done;
          state_next             = BK_IDLE;
        end
      end
      BK_REP: begin
        if (adv) begin
          emit                   = 1'b1;
          emit_data.last_of_step = (cnt == RUN_W'(1)) && cmd.last;
          emit_data.line_done    = (cnt == RUN_W'(1)) && cmd.done;
          cnt_next               = cnt - RUN_W'(1);
          if (cnt == RUN_W'(1)) begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
    res_valid_next = emit || (result_valid && !result_ready);
    res_next       = emit ? emit_data : result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= res_valid_next;
    end
    cmd    <= cmd_next;
    cnt    <= cnt_next;
    tens   <= tens_next;
    ones   <= ones_next;
    result <= res_next;
  end

  a_rep_count_live: assert property (@(posedge clk) disable iff (rst)
    state == BK_REP |-> cnt != '0)
    else $error("repeat started with an empty count");

endmodule

>>> src/text_run_length_codec.sv
// Run-length codec for one line of text, one byte per request. Mode 0 codes
// each run of a repeated byte as its decimal length followed by the byte
// (a single byte stands bare, runs split at MAX_RUN); mode 1 reads a decimal
// count and repeats the next non-digit that many times. A front end takes one
// byte per cycle and turns each run into a command for a four-entry queue; when
// a line end closes two runs at once it holds the second and takes no byte until
// the queue takes it, and it stalls while the queue is full. The back end loads
// each command from the queue in its idle state and then writes its bytes (up to
// three for a coded run, up to MAX_RUN for an expansion) at one byte per cycle
// while the output is not stalled, so it sets the output speed and, on long
// expansions, the input rate. Writing mode clears every partial run and count.
module text_run_length_codec #(
  parameter int MAX_RUN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              item_valid,
  output logic              item_ready,
  input  rlc_pkg::rlc_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output rlc_pkg::rlc_out_t result
);
  import rlc_pkg::*;

  logic     push;
  rlc_cmd_t push_cmd;
  logic     pop;
  rlc_cmd_t head;
  logic     q_full;
  logic     q_empty;

  rlc_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  rlc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rlc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
